// ===== rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] item_value;
    } deq_in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] popped_value;
        logic                  popped_valid;
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] back_value;
        logic                  ends_valid;
        logic [CNT_W-1:0]      entry_total;
        logic                  is_empty;
        logic [1:0]            status;
    } deq_out_t;

endpackage : deq_pkg
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of handles kept in a ring buffer memory, with the front and
// back handles cached in registers.
// ----------------------------------------------------------------------------
// Timing: the result strobe is registered from the accept; a pop that leaves
//   two or more entries first passes ST_READ (one memory read fetches the new end).
// Throughput: one item per cycle while not busy; such pops hold busy in ST_READ,
//   since the entry memory has a single read port. The receiver cannot stall.
// Reset: indexes, count and control clear at once; the entry memory is not
//   cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire deq_pkg::deq_in_t cmd,
    output deq_pkg::deq_out_t    rsp,
    output logic                 done
);
    import deq_pkg::*;

    // entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    // control and cached state
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] fval_reg, fval_next;
    logic [DATA_WIDTH-1:0] bval_reg, bval_next;
    logic                  end_back_reg, end_back_next;
    logic [DATA_WIDTH-1:0] pop_val_reg, pop_val_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  done_reg, done_next;
    deq_out_t              rsp_reg, rsp_next;

    logic                  accept;
    logic                  need_read;
    logic                  is_empty_q;
    logic                  is_full_q;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign accept     = start && (state_reg == ST_IDLE);
    assign is_empty_q = (count_reg == '0);
    assign is_full_q  = (count_reg == CNT_W'(DEPTH));

    // operation decode and update of indexes and cached ends
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = back_reg;
        rd_en         = 1'b0;
        rd_addr       = front_reg;
        need_read     = 1'b0;
        front_next    = front_reg;
        back_next     = back_reg;
        count_next    = count_reg;
        fval_next     = fval_reg;
        bval_next     = bval_reg;
        end_back_next = end_back_reg;
        pop_val_next  = pop_val_reg;
        pop_ok_next   = pop_ok_reg;
        stat_next     = stat_reg;
        if (state_reg == ST_READ)
        begin
            // fetched new end arrives from memory
            if (end_back_reg)
                bval_next = rd_data_reg;
            else
                fval_next = rd_data_reg;
        end
        else if (accept)
        begin
            pop_val_next = '0;
            pop_ok_next  = 1'b0;
            stat_next    = STAT_OK;
            case (cmd.op)
                OP_PUSH_BACK:
                begin
                    if (is_full_q)
                        stat_next = STAT_OVERFLOW;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_reg;
                        back_next  = ring_next(back_reg);
                        count_next = count_reg + 1'b1;
                        bval_next  = cmd.item_value;
                        if (is_empty_q)
                            fval_next = cmd.item_value;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (is_full_q)
                        stat_next = STAT_OVERFLOW;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_prev(front_reg);
                        front_next = ring_prev(front_reg);
                        count_next = count_reg + 1'b1;
                        fval_next  = cmd.item_value;
                        if (is_empty_q)
                            bval_next = cmd.item_value;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty_q)
                        stat_next = STAT_UNDERFLOW;
                    else
                    begin
                        pop_val_next  = fval_reg;
                        pop_ok_next   = 1'b1;
                        front_next    = ring_next(front_reg);
                        count_next    = count_reg - 1'b1;
                        end_back_next = 1'b0;
                        if (count_reg == CNT_W'(2))
                            fval_next = bval_reg;
                        else if (count_reg > CNT_W'(2))
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = ring_next(front_reg);
                            need_read = 1'b1;
                        end
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty_q)
                        stat_next = STAT_UNDERFLOW;
                    else
                    begin
                        pop_val_next  = bval_reg;
                        pop_ok_next   = 1'b1;
                        back_next     = ring_prev(back_reg);
                        count_next    = count_reg - 1'b1;
                        end_back_next = 1'b1;
                        if (count_reg == CNT_W'(2))
                            bval_next = fval_reg;
                        else if (count_reg > CNT_W'(2))
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = ring_prev(ring_prev(back_reg));
                            need_read = 1'b1;
                        end
                    end
                end
                default:
                begin
                    stat_next = STAT_OK;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && need_read)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result formation and strobe
    always_comb
    begin
        done_next             = 1'b0;
        rsp_next              = rsp_reg;
        if ((accept && !need_read) || (state_reg == ST_READ))
        begin
            done_next             = 1'b1;
            rsp_next.popped_value = pop_val_next;
            rsp_next.popped_valid = pop_ok_next;
            rsp_next.ends_valid   = (count_next != '0);
            rsp_next.front_value  = (count_next != '0) ? fval_next : '0;
            rsp_next.back_value   = (count_next != '0) ? bval_next : '0;
            rsp_next.entry_total  = count_next;
            rsp_next.is_empty     = (count_next == '0);
            rsp_next.status       = stat_next;
        end
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= cmd.item_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fval_reg     <= fval_next;
        bval_reg     <= bval_next;
        end_back_reg <= end_back_next;
        pop_val_reg  <= pop_val_next;
        pop_ok_reg   <= pop_ok_next;
        stat_reg     <= stat_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg == ST_READ);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule : double_ended_queue
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue. A shadow deque in the
// bench predicts every response. Commands are pushes at either end, pops
// from either end, queries and the unused op codes. The random part fills
// the queue past full, drains it past empty, and then runs mixed bursts.
// Sender idling changes from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam int         N_RANDOM     = 1400;
    localparam int         PHASE_LEN    = 150;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [2:0] OP_QUERY     = 3'd4;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    deq_in_t  cmd;
    deq_out_t rsp;

    // commands waiting to be driven, responses waiting to arrive
    deq_in_t  cmd_pending_q[$];
    deq_out_t rsp_expected_q[$];

    int issue_count;
    int accept_count;
    int err_count;
    int cycle_count;
    int n_push;
    int n_pop;
    int n_overflow;
    int n_underflow;
    int n_other;

    // shadow deque state
    logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
    int                    shadow_front;
    int                    shadow_back;
    int                    shadow_count;

    double_ended_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .rsp   (rsp),
        .done  (done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // apply one command to the shadow deque and return its response
    function automatic deq_out_t deque_apply(deq_in_t c);
        deq_out_t r;
        r        = '0;
        r.status = STAT_OK;
        case (c.op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                n_push++;
                if (shadow_count >= DEPTH)
                begin
                    r.status = STAT_OVERFLOW;
                    n_overflow++;
                end
                else if (c.op == OP_PUSH_BACK)
                begin
                    shadow_store[shadow_back] = c.item_value;
                    shadow_back  = (shadow_back + 1) % DEPTH;
                    shadow_count++;
                end
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_store[shadow_front] = c.item_value;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                n_pop++;
                if (shadow_count == 0)
                begin
                    r.status = STAT_UNDERFLOW;
                    n_underflow++;
                end
                else if (c.op == OP_POP_FRONT)
                begin
                    r.popped_value = shadow_store[shadow_front];
                    r.popped_valid = 1'b1;
                    shadow_front   = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
                else
                begin
                    shadow_back    = (shadow_back + DEPTH - 1) % DEPTH;
                    r.popped_value = shadow_store[shadow_back];
                    r.popped_valid = 1'b1;
                    shadow_count--;
                end
            end
            default: n_other++;
        endcase
        // ends are only reported while entries remain
        if (shadow_count != 0)
        begin
            r.front_value = shadow_store[shadow_front];
            r.back_value  = shadow_store[(shadow_back + DEPTH - 1) % DEPTH];
            r.ends_valid  = 1'b1;
        end
        r.entry_total = shadow_count[CNT_W-1:0];
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic add_cmd(logic [2:0] op, logic [DATA_WIDTH-1:0] value);
        deq_in_t c;
        c.op         = op;
        c.item_value = value;
        cmd_pending_q.push_back(c);
    endtask

    function automatic logic [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int idle_for_phase(int n);
        case ((n / PHASE_LEN) % 4)
            1:       return 57;
            2:       return 19;
            default: return 0;
        endcase
    endfunction

    // driver: next item goes out once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || accept_count == issue_count))
        begin
            if (cmd_pending_q.size() != 0 &&
                $urandom_range(99) >= idle_for_phase(issue_count))
            begin
                cmd         <= cmd_pending_q.pop_front();
                start       <= 1'b1;
                issue_count <= issue_count + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check responses, then record accepted items
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (done)
        begin
            if (rsp_expected_q.size() == 0)
            begin
                $error("response with none expected");
                err_count++;
            end
            else
            begin
                deq_out_t e;
                e = rsp_expected_q.pop_front();
                check_field("popped_value", e.popped_value, rsp.popped_value);
                check_field("popped_valid", e.popped_valid, rsp.popped_valid);
                check_field("front_value",  e.front_value,  rsp.front_value);
                check_field("back_value",   e.back_value,   rsp.back_value);
                check_field("ends_valid",   e.ends_valid,   rsp.ends_valid);
                check_field("entry_total",  e.entry_total,  rsp.entry_total);
                check_field("is_empty",     e.is_empty,     rsp.is_empty);
                check_field("status",       e.status,       rsp.status);
            end
        end
        if (rst_n && start && !busy)
        begin
            rsp_expected_q.push_back(deque_apply(cmd));
            accept_count <= accept_count + 1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int rand_total;
        int kind;
        int run_len;
        logic [2:0] op;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        issue_count  = 0;
        accept_count = 0;
        err_count    = 0;
        cycle_count  = 0;
        n_push       = 0;
        n_pop        = 0;
        n_overflow   = 0;
        n_underflow  = 0;
        n_other      = 0;
        shadow_front = 0;
        shadow_back  = 0;
        shadow_count = 0;

        // directed: empty pops, last-entry pops, extremes, unused ops
        add_cmd(OP_QUERY,      $urandom);
        add_cmd(OP_POP_FRONT,  $urandom);
        add_cmd(OP_POP_BACK,   $urandom);
        add_cmd(OP_PUSH_BACK,  '0);
        add_cmd(OP_POP_BACK,   '1);
        add_cmd(OP_PUSH_FRONT, '1);
        add_cmd(OP_POP_FRONT,  '0);
        add_cmd(OP_PUSH_BACK,  32'hAAAA_AAAA);
        add_cmd(OP_PUSH_FRONT, 32'h5555_5555);
        add_cmd(OP_PUSH_BACK,  '1);
        add_cmd(OP_PUSH_FRONT, '0);
        add_cmd(OP_QUERY,      '1);
        add_cmd(3'd5,          $urandom);
        add_cmd(3'd6,          $urandom);
        add_cmd(3'd7,          '1);
        add_cmd(OP_POP_FRONT,  $urandom);
        add_cmd(OP_POP_BACK,   $urandom);
        add_cmd(OP_POP_FRONT,  $urandom);
        add_cmd(OP_POP_BACK,   $urandom);
        add_cmd(OP_POP_BACK,   $urandom);
        add_cmd(OP_PUSH_FRONT, $urandom);
        add_cmd(OP_POP_BACK,   $urandom);

        // fill past full, work near full, then drain past empty
        rand_total = 0;
        repeat (DEPTH + 14)
        begin
            add_cmd($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_value());
            rand_total++;
        end
        repeat (30)
        begin
            add_cmd(3'($urandom_range(7)), rand_value());
            rand_total++;
        end
        repeat (DEPTH + 30)
        begin
            add_cmd($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
            rand_total++;
        end

        // mixed bursts: push heavy, pop heavy, any op, balanced
        while (rand_total < N_RANDOM)
        begin
            kind    = $urandom_range(3);
            run_len = $urandom_range(120, 10);
            repeat (run_len)
            begin
                case (kind)
                    0: op = ($urandom_range(99) < 75) ? 3'($urandom_range(1))
                                                      : 3'($urandom_range(7));
                    1: op = ($urandom_range(99) < 75) ? 3'($urandom_range(3, 2))
                                                      : 3'($urandom_range(7));
                    2: op = 3'($urandom_range(7));
                    default: op = 3'($urandom_range(3));
                endcase
                add_cmd(op, rand_value());
                rand_total++;
            end
        end

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (cmd_pending_q.size() == 0 && accept_count == issue_count &&
              rsp_expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (rsp_expected_q.size() != 0)
        begin
            $error("%0d responses never arrived", rsp_expected_q.size());
            err_count++;
        end
        $display("ran %0d commands: %0d pushes (%0d on full), %0d pops (%0d on empty)",
                 accept_count, n_push, n_overflow, n_pop, n_underflow);
        $display("%0d query or unused-op commands, %0d mismatches", n_other, err_count);
        if (err_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue.f =====
rtl/deq_pkg.sv
rtl/double_ended_queue.sv
verif/tb_top.sv
